@@ sv/scd_pkg.sv @@
package scd_pkg;

   localparam int DELAY_DEPTH_DEFAULT = 256;
   localparam int FRAC_BITS           = 30;
   localparam int CSR_INDEX_W         = 3;
   localparam int CSR_DATA_W          = 32;

   localparam logic [14:0] DRY_GAIN_RESET   = 15'd19661;
   localparam logic [14:0] WET_GAIN_RESET   = 15'd9830;
   localparam logic [30:0] RATE_HIGH_RESET  = 31'd1084479242;
   localparam logic [30:0] RATE_LOW_RESET   = 31'd1063004406;
   localparam logic [14:0] SWEEP_ONE_RESET  = 15'd3221;
   localparam logic [14:0] SWEEP_TWO_RESET  = 15'd2147;
   localparam logic [31:0] RATE_RESET       = 32'd1073741824;
   localparam logic signed [15:0] STEP_ONE_RESET = 16'sd1074;
   localparam logic signed [15:0] STEP_TWO_RESET = 16'sd215;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DRY_GAIN       = 3'd0,
      CSR_WET_GAIN       = 3'd1,
      CSR_RATE_HIGH      = 3'd2,
      CSR_RATE_LOW       = 3'd3,
      CSR_SWEEP_STEP_ONE = 3'd4,
      CSR_SWEEP_STEP_TWO = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] left_sample;
      logic signed [15:0] right_sample;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] left_result;
      logic signed [15:0] right_result;
   } rsp_word_type;

   // which delay-line address is read this cycle
   typedef enum logic [1:0] {
      RD_TAP_ONE_CUR  = 2'd0,
      RD_TAP_ONE_NEXT = 2'd1,
      RD_TAP_TWO_CUR  = 2'd2,
      RD_TAP_TWO_NEXT = 2'd3
   } rd_sel_type;

   typedef enum logic [2:0] {
      MUL_DIFF_ONE = 3'd0,
      MUL_DIFF_TWO = 3'd1,
      MUL_WET      = 3'd2,
      MUL_LEFT     = 3'd3,
      MUL_RIGHT    = 3'd4
   } mul_sel_type;

   typedef struct packed {
      logic        mem_write;
      rd_sel_type  rd_sel;
      logic        load_a;
      logic        load_b;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        tap_first;
      logic        tap_add;
      logic        rate_one;
      logic        pos_one;
      logic        rate_two;
      logic        pos_two;
      logic        keep_wet;
      logic        keep_left;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

@@ sv/scd_ram.sv @@
module scd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = scd_pkg::DELAY_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/scd_ctrl.sv @@
module scd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  scd_pkg::status_type  status,
   output scd_pkg::cmd_type     cmd
);

   typedef enum logic [11:0] {
      S_IDLE      = 12'b000000000001,
      S_RD_I1     = 12'b000000000010,
      S_RD_N1     = 12'b000000000100,
      S_RD_I2     = 12'b000000001000,
      S_RD_N2     = 12'b000000010000,
      S_TAP1      = 12'b000000100000,
      S_MUL2      = 12'b000001000000,
      S_TAP2      = 12'b000010000000,
      S_MUL_WET   = 12'b000100000000,
      S_MUL_LEFT  = 12'b001000000000,
      S_MUL_RIGHT = 12'b010000000000,
      S_DONE      = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.rd_sel  = scd_pkg::RD_TAP_ONE_CUR;
      cmd.mul_sel = scd_pkg::MUL_DIFF_ONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.mem_write = 1'b1;
               state_in      = S_RD_I1;
            end
         end
         S_RD_I1: begin
            cmd.rd_sel = scd_pkg::RD_TAP_ONE_CUR;
            state_in   = S_RD_N1;
         end
         S_RD_N1: begin
            cmd.rd_sel = scd_pkg::RD_TAP_ONE_NEXT;
            cmd.load_a = 1'b1;
            state_in   = S_RD_I2;
         end
         S_RD_I2: begin
            cmd.rd_sel = scd_pkg::RD_TAP_TWO_CUR;
            cmd.load_b = 1'b1;
            state_in   = S_RD_N2;
         end
         S_RD_N2: begin
            // tap one interpolation starts, tap two current entry lands in a
            cmd.rd_sel   = scd_pkg::RD_TAP_TWO_NEXT;
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = scd_pkg::MUL_DIFF_ONE;
            cmd.load_a   = 1'b1;
            cmd.rate_one = 1'b1;
            state_in     = S_TAP1;
         end
         S_TAP1: begin
            cmd.load_b    = 1'b1;
            cmd.tap_first = 1'b1;
            cmd.pos_one   = 1'b1;
            state_in      = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = scd_pkg::MUL_DIFF_TWO;
            cmd.rate_two = 1'b1;
            state_in     = S_TAP2;
         end
         S_TAP2: begin
            cmd.tap_add = 1'b1;
            cmd.pos_two = 1'b1;
            state_in    = S_MUL_WET;
         end
         S_MUL_WET: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = scd_pkg::MUL_WET;
            state_in    = S_MUL_LEFT;
         end
         S_MUL_LEFT: begin
            cmd.keep_wet = 1'b1;
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = scd_pkg::MUL_LEFT;
            state_in     = S_MUL_RIGHT;
         end
         S_MUL_RIGHT: begin
            cmd.keep_left = 1'b1;
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = scd_pkg::MUL_RIGHT;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ sv/scd_datapath.sv @@
module scd_datapath #(
   parameter int DELAY_DEPTH = scd_pkg::DELAY_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  scd_pkg::cmd_type                    cmd,
   output scd_pkg::status_type                 status,
   input  scd_pkg::req_word_type               req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output scd_pkg::rsp_word_type               rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [scd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [scd_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int FB = scd_pkg::FRAC_BITS;
   localparam int AW = $clog2(DELAY_DEPTH);
   localparam int PW = AW + FB;
   localparam int SW = PW + 2;
   localparam int FW = $clog2(DELAY_DEPTH + 1);
   localparam logic [SW-1:0] POS_LIMIT = SW'(DELAY_DEPTH) << FB;
   localparam logic [AW-1:0] LAST_ADDR = AW'(DELAY_DEPTH - 1);
   localparam logic [FW-1:0] FILL_FULL = FW'(DELAY_DEPTH);

   // configuration
   logic [14:0] dry_gain_ff, wet_gain_ff, sweep_one_ff, sweep_two_ff;
   logic [30:0] rate_high_ff, rate_low_ff;

   // delay line control
   logic [AW-1:0] wp_ff;
   logic [FW-1:0] fill_ff;
   logic          rd_valid_ff;
   logic [AW-1:0] rd_addr;
   logic [15:0]   ram_rdata;
   logic signed [15:0] rd_word;

   // tap state
   logic [PW-1:0]      pos_one_ff, pos_two_ff;
   logic [31:0]        rate_one_ff, rate_two_ff;
   logic signed [15:0] step_one_ff, step_two_ff;
   logic [31:0]        rate_one_in, rate_two_in;
   logic [AW-1:0]      idx_one, idx_two, nxt_one, nxt_two;

   // arithmetic
   logic signed [15:0] left_ff, right_ff;
   logic signed [15:0] sa_ff, sb_ff, base_ff;
   logic signed [16:0] taps_ff;
   logic signed [32:0] wet_ff;
   logic signed [15:0] left_res_ff;
   logic signed [47:0] prod_ff;
   logic signed [16:0] mul_a;
   logic [29:0]        mul_b;
   logic signed [16:0] diff;
   logic signed [47:0] tap_rnd;
   logic signed [16:0] tap_val;
   logic signed [15:0] mix_res;

   logic                  rsp_valid_ff;
   scd_pkg::rsp_word_type rsp_data_ff;

   function automatic logic [31:0] rate_next(input logic [31:0] rate,
                                             input logic signed [15:0] step);
      logic signed [33:0] sum;
      sum = $signed({2'b00, rate}) + 34'(step);
      if (sum[33]) begin
         return '0;
      end else if (sum[32]) begin
         return '1;
      end
      return sum[31:0];
   endfunction

   function automatic logic signed [15:0] step_next(input logic [31:0] rate,
                                                    input logic signed [15:0] step,
                                                    input logic [14:0] mag,
                                                    input logic [30:0] high,
                                                    input logic [30:0] low);
      logic signed [15:0] res;
      res = step;
      if (rate > {1'b0, high}) begin
         res = -$signed({1'b0, mag});
      end
      // lower bound wins when both hold
      if (rate < {1'b0, low}) begin
         res = $signed({1'b0, mag});
      end
      return res;
   endfunction

   function automatic logic [PW-1:0] pos_next(input logic [PW-1:0] pos,
                                              input logic [31:0] rate);
      logic [SW-1:0] sum;
      sum = SW'(pos) + SW'(rate);
      if (sum >= POS_LIMIT) begin
         sum = sum - POS_LIMIT;
      end
      return sum[PW-1:0];
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [32:0] v);
      if (v > 33'sd32767) begin
         return 16'sh7fff;
      end else if (v < -33'sd32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dry_gain_ff  <= scd_pkg::DRY_GAIN_RESET;
         wet_gain_ff  <= scd_pkg::WET_GAIN_RESET;
         rate_high_ff <= scd_pkg::RATE_HIGH_RESET;
         rate_low_ff  <= scd_pkg::RATE_LOW_RESET;
         sweep_one_ff <= scd_pkg::SWEEP_ONE_RESET;
         sweep_two_ff <= scd_pkg::SWEEP_TWO_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            scd_pkg::CSR_DRY_GAIN:       dry_gain_ff  <= csr_data[14:0];
            scd_pkg::CSR_WET_GAIN:       wet_gain_ff  <= csr_data[14:0];
            scd_pkg::CSR_RATE_HIGH:      rate_high_ff <= csr_data[30:0];
            scd_pkg::CSR_RATE_LOW:       rate_low_ff  <= csr_data[30:0];
            scd_pkg::CSR_SWEEP_STEP_ONE: sweep_one_ff <= csr_data[14:0];
            scd_pkg::CSR_SWEEP_STEP_TWO: sweep_two_ff <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   // tap addresses: positions always stay below the line length
   assign idx_one = pos_one_ff[PW-1:FB];
   assign idx_two = pos_two_ff[PW-1:FB];
   assign nxt_one = (idx_one == LAST_ADDR) ? '0 : idx_one + 1'b1;
   assign nxt_two = (idx_two == LAST_ADDR) ? '0 : idx_two + 1'b1;

   always_comb begin
      unique case (cmd.rd_sel)
         scd_pkg::RD_TAP_ONE_CUR:  rd_addr = idx_one;
         scd_pkg::RD_TAP_ONE_NEXT: rd_addr = nxt_one;
         scd_pkg::RD_TAP_TWO_CUR:  rd_addr = idx_two;
         scd_pkg::RD_TAP_TWO_NEXT: rd_addr = nxt_two;
         default:                  rd_addr = idx_one;
      endcase
   end

   scd_ram #(
      .WIDTH (16),
      .DEPTH (DELAY_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.mem_write),
      .wr_addr (wp_ff),
      .wr_data (req_data.left_sample),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   // entries at or above the fill count were never written and read as zero
   assign rd_word = rd_valid_ff ? $signed(ram_rdata) : 16'sd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         fill_ff <= '0;
      end else if (cmd.mem_write) begin
         wp_ff <= (wp_ff == LAST_ADDR) ? '0 : wp_ff + 1'b1;
         if (fill_ff != FILL_FULL) begin
            fill_ff <= fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_valid_ff <= (FW'(rd_addr) < fill_ff);
      if (cmd.mem_write) begin
         left_ff  <= req_data.left_sample;
         right_ff <= req_data.right_sample;
      end
      if (cmd.load_a) begin
         sa_ff <= rd_word;
      end
      if (cmd.load_b) begin
         sb_ff <= rd_word;
      end
   end

   assign rate_one_in = rate_next(rate_one_ff, step_one_ff);
   assign rate_two_in = rate_next(rate_two_ff, step_two_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_one_ff  <= '0;
         pos_two_ff  <= '0;
         rate_one_ff <= scd_pkg::RATE_RESET;
         rate_two_ff <= scd_pkg::RATE_RESET;
         step_one_ff <= scd_pkg::STEP_ONE_RESET;
         step_two_ff <= scd_pkg::STEP_TWO_RESET;
      end else begin
         if (cmd.rate_one) begin
            rate_one_ff <= rate_one_in;
            step_one_ff <= step_next(rate_one_in, step_one_ff, sweep_one_ff,
                                     rate_high_ff, rate_low_ff);
         end
         if (cmd.pos_one) begin
            pos_one_ff <= pos_next(pos_one_ff, rate_one_ff);
         end
         if (cmd.rate_two) begin
            rate_two_ff <= rate_two_in;
            step_two_ff <= step_next(rate_two_in, step_two_ff, sweep_two_ff,
                                     rate_high_ff, rate_low_ff);
         end
         if (cmd.pos_two) begin
            pos_two_ff <= pos_next(pos_two_ff, rate_two_ff);
         end
      end
   end

   // shared multiplier: signed 17 bits by unsigned 30 bits
   assign diff = $signed({sb_ff[15], sb_ff}) - $signed({sa_ff[15], sa_ff});

   always_comb begin
      unique case (cmd.mul_sel)
         scd_pkg::MUL_DIFF_ONE: begin
            mul_a = diff;
            mul_b = pos_one_ff[FB-1:0];
         end
         scd_pkg::MUL_DIFF_TWO: begin
            mul_a = diff;
            mul_b = pos_two_ff[FB-1:0];
         end
         scd_pkg::MUL_WET: begin
            mul_a = taps_ff;
            mul_b = 30'(wet_gain_ff);
         end
         scd_pkg::MUL_LEFT: begin
            mul_a = 17'(left_ff);
            mul_b = 30'(dry_gain_ff);
         end
         scd_pkg::MUL_RIGHT: begin
            mul_a = 17'(right_ff);
            mul_b = 30'(dry_gain_ff);
         end
         default: begin
            mul_a = diff;
            mul_b = pos_one_ff[FB-1:0];
         end
      endcase
   end

   // tap = current + round_half_up(diff * frac)
   assign tap_rnd = prod_ff + 48'sd536870912;
   assign tap_val = $signed({base_ff[15], base_ff}) + tap_rnd[46:30];

   // mix: round half up to Q.15 then clamp
   always_comb begin
      logic signed [47:0] s;
      s       = prod_ff + 48'(wet_ff) + 48'sd16384;
      mix_res = sat16(s[47:15]);
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= mul_a * $signed({1'b0, mul_b});
      end
      if (cmd.mul_en &&
          (cmd.mul_sel == scd_pkg::MUL_DIFF_ONE || cmd.mul_sel == scd_pkg::MUL_DIFF_TWO)) begin
         base_ff <= sa_ff;
      end
      if (cmd.tap_first) begin
         taps_ff <= tap_val;
      end else if (cmd.tap_add) begin
         taps_ff <= taps_ff + tap_val;
      end
      if (cmd.keep_wet) begin
         wet_ff <= prod_ff[32:0];
      end
      if (cmd.keep_left) begin
         left_res_ff <= mix_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff.left_result  <= left_res_ff;
         rsp_data_ff.right_result <= mix_res;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

endmodule

@@ sv/stereo_chorus_delay_core.sv @@
// Stereo chorus: each req word writes its left sample into a circular delay line of
// DELAY_DEPTH entries, two swept taps read it with linear interpolation, and one rsp
// word carries both dry plus wet mixes. Words are handled one at a time, and the
// controller steps through its states in order, because the four delay-line reads go
// through the single read port of the line memory and the five products (two
// interpolations, wet gain, two dry gains) share one multiplier. The next word is
// taken once the result has moved into the output register, which holds it until
// rsp_ready; while it is held, a finished result waits in the controller's last state.
// The delay line reads as zero where it was never written, so no clearing pass follows
// reset. Configuration writes are always accepted and take effect at once; write them
// only while no item is in work.
module stereo_chorus_delay_core #(
   parameter int DELAY_DEPTH = scd_pkg::DELAY_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  scd_pkg::req_word_type            req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output scd_pkg::rsp_word_type            rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [scd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [scd_pkg::CSR_DATA_W-1:0]   csr_data
);

   scd_pkg::cmd_type    cmd;
   scd_pkg::status_type status;

   scd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   scd_datapath #(
      .DELAY_DEPTH (DELAY_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule
